// File: sv/buffer_pool_slot_manager_defines.svh
// Assertion macros for the buffer pool slot manager
`ifndef BUFFER_POOL_SLOT_MANAGER_DEFINES_SVH
`define BUFFER_POOL_SLOT_MANAGER_DEFINES_SVH
// implication checked on every clock edge outside reset
`define BPSM_ASSERT_IMP(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");
// next-cycle implication
`define BPSM_ASSERT_NXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");
`endif

// File: sv/bpsm_pkg.sv
// Package for the buffer pool slot manager: sizes, codes and types
package bpsm_pkg;
    localparam int SLOTS_DEF        = 16;
    localparam int HANDLE_BITS_DEF  = 32;
    localparam int COUNTER_BITS_DEF = 16;

    localparam logic [1:0] ACT_GET    = 2'd0;
    localparam logic [1:0] ACT_RETURN = 2'd1;
    localparam logic [1:0] ACT_PIN    = 2'd2;
    localparam logic [1:0] ACT_FLUSH  = 2'd3;

    localparam logic [2:0] ST_HIT      = 3'd0;
    localparam logic [2:0] ST_FILLED   = 3'd1;
    localparam logic [2:0] ST_REPLACED = 3'd2;
    localparam logic [2:0] ST_NOVICTIM = 3'd3;
    localparam logic [2:0] ST_ABSENT   = 3'd4;
    localparam logic [2:0] ST_FLUSH    = 3'd5;

    localparam logic REG_USE_WEIGHT = 1'b0;
    localparam logic REG_GAP_WEIGHT = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE, S_SCAN, S_APPLY, S_FLUSH, S_OUT
    } state_t;

    // operation broadcast to every cell for one cycle
    typedef struct packed {
        logic touch;     // p borrowed, use+1, gap 0; others in use age
        logic fill;      // p takes a new handle, borrowed, use 1, gap 0
        logic ret;       // p: clear borrowed and pinned, or in dirty
        logic pin;       // p: set pinned
        logic dirty_in;
        logic clear_all; // pool emptied
    } cell_cmd_t;
endpackage

// File: sv/bpsm_cell.sv
// One directory cell: slot state, plus a stage of the search chain
module bpsm_cell #(
    parameter int SLOTS        = bpsm_pkg::SLOTS_DEF,
    parameter int HANDLE_BITS  = bpsm_pkg::HANDLE_BITS_DEF,
    parameter int COUNTER_BITS = bpsm_pkg::COUNTER_BITS_DEF,
    parameter int IDX          = 0
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [HANDLE_BITS-1:0]   key,
    input  logic [7:0]               use_weight,
    input  logic [7:0]               gap_weight,
    input  logic                     in_use,
    input  logic                     target,
    input  bpsm_pkg::cell_cmd_t      cmd,
    input  logic [HANDLE_BITS-1:0]   new_handle,
    // search chain from the left neighbour
    input  logic                     hit_in,
    input  logic [$clog2(SLOTS)-1:0] hit_idx_in,
    input  logic                     vic_in,
    input  logic [$clog2(SLOTS)-1:0] vic_idx_in,
    input  logic signed [COUNTER_BITS+9:0] vic_score_in,
    output logic                     hit_out,
    output logic [$clog2(SLOTS)-1:0] hit_idx_out,
    output logic                     vic_out,
    output logic [$clog2(SLOTS)-1:0] vic_idx_out,
    output logic signed [COUNTER_BITS+9:0] vic_score_out,
    output logic [HANDLE_BITS-1:0]   handle_q,
    output logic                     dirty_q,
    output logic                     borrowed_q
);
    localparam int IW = $clog2(SLOTS);
    localparam int SW = COUNTER_BITS + 10;
    localparam logic [COUNTER_BITS-1:0] CMAX = {COUNTER_BITS{1'b1}};

    logic [HANDLE_BITS-1:0]  handle_reg;
    logic [COUNTER_BITS-1:0] use_reg, gap_reg;
    logic pinned_reg, borrowed_reg, dirty_reg;
    logic [COUNTER_BITS+7:0] use_prod_reg, gap_prod_reg;
    logic hit_reg, vic_reg;
    logic [IW-1:0] hit_idx_reg, vic_idx_reg;
    logic signed [SW-1:0] vic_score_reg;
    logic signed [SW-1:0] my_score;
    logic my_hit, my_cand;

    // products registered at scan start; counts hold during the scan
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            use_prod_reg <= use_reg * use_weight;
            gap_prod_reg <= gap_reg * gap_weight;
        end
    end

    assign my_score = $signed({2'b00, use_prod_reg}) - $signed({2'b00, gap_prod_reg});
    assign my_hit   = in_use && (handle_reg == key);
    assign my_cand  = in_use && !pinned_reg && !borrowed_reg;

    // chain stage: earliest hit wins, strictly lower score wins
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg <= 1'b0;
            vic_reg <= 1'b0;
        end
        else
        begin
            hit_reg <= hit_in || my_hit;
            vic_reg <= vic_in || my_cand;
        end
    end

    always_ff @(posedge clk)
    begin
        hit_idx_reg <= hit_in ? hit_idx_in : IW'(IDX);
        if (vic_in && (!my_cand || vic_score_in <= my_score))
        begin
            vic_idx_reg   <= vic_idx_in;
            vic_score_reg <= vic_score_in;
        end
        else
        begin
            vic_idx_reg   <= IW'(IDX);
            vic_score_reg <= my_score;
        end
    end

    // slot state update
    always_ff @(posedge clk)
    begin
        if (cmd.fill && target)
        begin
            handle_reg   <= new_handle;
            use_reg      <= {{(COUNTER_BITS-1){1'b0}}, 1'b1};
            gap_reg      <= '0;
            pinned_reg   <= 1'b0;
            borrowed_reg <= 1'b1;
            dirty_reg    <= 1'b0;
        end
        else if (cmd.touch && target)
        begin
            borrowed_reg <= 1'b1;
            if (use_reg != CMAX)
                use_reg <= use_reg + 1'b1;
            gap_reg <= '0;
        end
        else if (cmd.touch && in_use)
        begin
            if (gap_reg != CMAX)
                gap_reg <= gap_reg + 1'b1;
        end
        else if (cmd.ret && target)
        begin
            borrowed_reg <= 1'b0;
            pinned_reg   <= 1'b0;
            dirty_reg    <= dirty_reg | cmd.dirty_in;
        end
        else if (cmd.pin && target)
        begin
            pinned_reg <= 1'b1;
        end
    end

    assign hit_out       = hit_reg;
    assign hit_idx_out   = hit_idx_reg;
    assign vic_out       = vic_reg;
    assign vic_idx_out   = vic_idx_reg;
    assign vic_score_out = vic_score_reg;
    assign handle_q      = handle_reg;
    assign dirty_q       = dirty_reg;
    assign borrowed_q    = borrowed_reg;
endmodule

// File: sv/buffer_pool_slot_manager.sv
// Buffer pool slot manager: chain of SLOTS cells with a sequencing controller
// Get, return and pin pass through the scan, apply and out states to a result.
// Flush gives one result per cycle per slot in use (output may stall it), or
// one flush_empty result if the pool is empty. One item at a time: a new item
// is taken only once the last result has been taken. Reset: asynchronous,
// pool empty, both weights 1; slot contents are undefined until filled.
`include "buffer_pool_slot_manager_defines.svh"
module buffer_pool_slot_manager #(
    parameter int SLOTS        = bpsm_pkg::SLOTS_DEF,
    parameter int HANDLE_BITS  = bpsm_pkg::HANDLE_BITS_DEF,
    parameter int COUNTER_BITS = bpsm_pkg::COUNTER_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  action,
    input  logic [31:0] handle,
    input  logic        mark_dirty,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  status,
    output logic [3:0]  slot,
    output logic [31:0] victim_handle,
    output logic        needs_writeback,
    output logic        flush_empty,
    output logic        last,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [7:0]  cfg_data
);
    localparam int IW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);
    localparam int SW = COUNTER_BITS + 10;
    localparam int HC = (HANDLE_BITS < 32) ? HANDLE_BITS : 32;

    bpsm_pkg::state_t state_reg, state_next;
    logic [CW-1:0] used_reg;
    logic [7:0] use_w_reg, gap_w_reg;
    logic [1:0] act_reg;
    logic [HANDLE_BITS-1:0] key_reg;
    logic dirty_in_reg;
    logic [CW-1:0] cnt_reg;
    logic [IW-1:0] fidx_reg;
    logic [2:0] st_reg;
    logic [IW-1:0] sl_reg;
    logic [31:0] vh_reg;
    logic wb_reg, fe_reg, last_reg;

    logic hit_c [SLOTS+1];
    logic vic_c [SLOTS+1];
    logic [IW-1:0] hidx_c [SLOTS+1];
    logic [IW-1:0] vidx_c [SLOTS+1];
    logic signed [SW-1:0] vsc_c [SLOTS+1];
    logic [HANDLE_BITS-1:0] h_q [SLOTS];
    logic d_q [SLOTS];
    logic b_q [SLOTS];
    logic [IW-1:0] tgt;
    bpsm_pkg::cell_cmd_t cmd;
    logic start, accept, done;

    assign hit_c[0]  = 1'b0;
    assign vic_c[0]  = 1'b0;
    assign hidx_c[0] = '0;
    assign vidx_c[0] = '0;
    assign vsc_c[0]  = '0;

    genvar g;
    generate
        for (g = 0; g < SLOTS; g++)
        begin : g_cell
            bpsm_cell #(.SLOTS(SLOTS), .HANDLE_BITS(HANDLE_BITS),
                        .COUNTER_BITS(COUNTER_BITS), .IDX(g)) u_cell (
                .clk(clk), .rst_n(rst_n), .start(start), .key(key_reg),
                .use_weight(use_w_reg), .gap_weight(gap_w_reg),
                .in_use(CW'(g) < used_reg), .target(tgt == IW'(g)), .cmd(cmd),
                .new_handle(key_reg),
                .hit_in(hit_c[g]), .hit_idx_in(hidx_c[g]),
                .vic_in(vic_c[g]), .vic_idx_in(vidx_c[g]), .vic_score_in(vsc_c[g]),
                .hit_out(hit_c[g+1]), .hit_idx_out(hidx_c[g+1]),
                .vic_out(vic_c[g+1]), .vic_idx_out(vidx_c[g+1]),
                .vic_score_out(vsc_c[g+1]),
                .handle_q(h_q[g]), .dirty_q(d_q[g]), .borrowed_q(b_q[g]));
        end
    endgenerate

    // a register write never lands on the same edge as an item transfer
    assign in_ready  = (state_reg == bpsm_pkg::S_IDLE);
    assign cfg_ready = (state_reg == bpsm_pkg::S_IDLE) && !in_valid;
    assign accept    = in_valid && in_ready;
    assign start     = accept;
    assign done      = out_valid && out_ready;

    // pool full test and lookup outcome at end of chain
    logic full, hit_f, vic_f;
    assign full  = (used_reg == CW'(SLOTS));
    assign hit_f = hit_c[SLOTS];
    assign vic_f = vic_c[SLOTS];

    // target slot for the apply cycle
    always_comb
    begin
        if (hit_f)
            tgt = hidx_c[SLOTS];
        else if (!full)
            tgt = used_reg[IW-1:0];
        else
            tgt = vidx_c[SLOTS];
    end

    // command to cells; a fill also ages every other slot in use
    always_comb
    begin
        cmd = '0;
        cmd.dirty_in = dirty_in_reg;
        if (state_reg == bpsm_pkg::S_APPLY)
        begin
            case (act_reg)
                bpsm_pkg::ACT_GET:
                begin
                    cmd.fill  = !hit_f && (!full || vic_f);
                    cmd.touch = hit_f || cmd.fill;
                end
                bpsm_pkg::ACT_RETURN: cmd.ret = hit_f;
                bpsm_pkg::ACT_PIN:    cmd.pin = hit_f;
                default: ;
            endcase
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            bpsm_pkg::S_IDLE:
                if (accept)
                    state_next = (action == bpsm_pkg::ACT_FLUSH) ?
                                 bpsm_pkg::S_FLUSH : bpsm_pkg::S_SCAN;
            bpsm_pkg::S_SCAN:
                if (cnt_reg == CW'(SLOTS)) state_next = bpsm_pkg::S_APPLY;
            bpsm_pkg::S_APPLY: state_next = bpsm_pkg::S_OUT;
            bpsm_pkg::S_FLUSH:
                if (done && last_reg) state_next = bpsm_pkg::S_IDLE;
            bpsm_pkg::S_OUT:
                if (done) state_next = bpsm_pkg::S_IDLE;
            default: state_next = bpsm_pkg::S_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        out_valid = (state_reg == bpsm_pkg::S_OUT) ||
                    (state_reg == bpsm_pkg::S_FLUSH);
    end

    // flush entry values for the slot in view
    logic [2:0] f_st;
    logic [IW-1:0] f_sl;
    logic [31:0] f_vh;
    logic f_wb, f_fe, f_last;
    always_comb
    begin
        f_st   = bpsm_pkg::ST_FLUSH;
        f_sl   = fidx_reg;
        f_vh   = 32'(h_q[fidx_reg][HC-1:0]);
        f_wb   = d_q[fidx_reg] || b_q[fidx_reg];
        f_fe   = 1'b0;
        f_last = (CW'(fidx_reg) + 1'b1 == used_reg);
        if (used_reg == '0)
        begin
            f_sl   = '0;
            f_vh   = '0;
            f_wb   = 1'b0;
            f_fe   = 1'b1;
            f_last = 1'b1;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bpsm_pkg::S_IDLE;
            used_reg  <= '0;
            use_w_reg <= 8'd1;
            gap_w_reg <= 8'd1;
            cnt_reg   <= '0;
            fidx_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == bpsm_pkg::REG_USE_WEIGHT) use_w_reg <= cfg_data;
                else gap_w_reg <= cfg_data;
            end
            if (accept)
            begin
                cnt_reg  <= '0;
                fidx_reg <= '0;
            end
            else if (state_reg == bpsm_pkg::S_SCAN)
                cnt_reg <= cnt_reg + 1'b1;
            if (state_reg == bpsm_pkg::S_APPLY && cmd.fill && !full)
                used_reg <= used_reg + 1'b1;
            if (state_reg == bpsm_pkg::S_FLUSH && done)
            begin
                if (last_reg) used_reg <= '0;
                else fidx_reg <= fidx_reg + 1'b1;
            end
        end
    end

    // flush entry follows fidx combinationally via last_reg mirror
    always_comb last_reg = (state_reg == bpsm_pkg::S_FLUSH) ? f_last : 1'b1;

    // captured item and result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            act_reg      <= action;
            key_reg      <= HANDLE_BITS'(handle);
            dirty_in_reg <= mark_dirty;
        end
        if (state_reg == bpsm_pkg::S_APPLY)
        begin
            st_reg <= bpsm_pkg::ST_HIT;
            sl_reg <= tgt;
            vh_reg <= '0;
            wb_reg <= 1'b0;
            fe_reg <= 1'b0;
            if (!hit_f)
            begin
                if (act_reg != bpsm_pkg::ACT_GET)
                begin
                    st_reg <= bpsm_pkg::ST_ABSENT;
                    sl_reg <= '0;
                end
                else if (!full)
                    st_reg <= bpsm_pkg::ST_FILLED;
                else if (vic_f)
                begin
                    st_reg <= bpsm_pkg::ST_REPLACED;
                    vh_reg <= 32'(h_q[tgt][HC-1:0]);
                    wb_reg <= d_q[tgt];
                end
                else
                begin
                    st_reg <= bpsm_pkg::ST_NOVICTIM;
                    sl_reg <= '0;
                end
            end
        end
    end

    logic flushing;
    assign flushing        = (state_reg == bpsm_pkg::S_FLUSH);
    assign status          = flushing ? f_st : st_reg;
    assign slot            = 4'(flushing ? f_sl : sl_reg);
    assign victim_handle   = flushing ? f_vh : vh_reg;
    assign needs_writeback = flushing ? f_wb : wb_reg;
    assign flush_empty     = flushing ? f_fe : fe_reg;
    assign last            = 1'b1 & (flushing ? f_last : 1'b1);

    `BPSM_ASSERT_IMP(a_no_in_busy, clk, rst_n, state_reg != bpsm_pkg::S_IDLE, !in_ready)
    `BPSM_ASSERT_IMP(a_used_max, clk, rst_n, 1'b1, used_reg <= CW'(SLOTS))
    `BPSM_ASSERT_NXT(a_apply_out, clk, rst_n, state_reg == bpsm_pkg::S_APPLY,
                     state_reg == bpsm_pkg::S_OUT)
    `BPSM_ASSERT_NXT(a_flush_clear, clk, rst_n, flushing && done && f_last, used_reg == '0)
endmodule

// File: sim/tb_buffer_pool_slot_manager.sv
// Testbench for the buffer pool slot manager: directed and random traffic with a scoreboard
`timescale 1ns / 100ps
module tb_buffer_pool_slot_manager;

    localparam int NSLOT = bpsm_pkg::SLOTS_DEF;
    localparam logic [15:0] CNT_SAT = 16'hFFFF;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 40;

    typedef struct packed {
        logic [2:0]  status;
        logic [3:0]  slot;
        logic [31:0] victim_handle;
        logic        needs_writeback;
        logic        flush_empty;
        logic        last;
    } pool_result_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  action;
    logic [31:0] handle;
    logic        mark_dirty;
    logic        out_valid;
    logic        out_ready;
    logic [2:0]  status;
    logic [3:0]  slot;
    logic [31:0] victim_handle;
    logic        needs_writeback;
    logic        flush_empty;
    logic        last;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_index;
    logic [7:0]  cfg_data;

    // shadow pool state
    logic [7:0]  w_use;
    logic [7:0]  w_gap;
    int          used;
    logic [31:0] p_handle [NSLOT];
    logic [15:0] p_use    [NSLOT];
    logic [15:0] p_gap    [NSLOT];
    logic        p_pin    [NSLOT];
    logic        p_borrow [NSLOT];
    logic        p_dirty  [NSLOT];

    pool_result_t pending_results [$];
    int errors = 0;
    int mismatches = 0;
    int results_seen = 0;
    int items_sent;
    int cycles = 0;
    int send_idle_pct;
    int recv_idle_pct;
    bit hold_off;

    buffer_pool_slot_manager u_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .action(action), .handle(handle), .mark_dirty(mark_dirty),
        .out_valid(out_valid), .out_ready(out_ready),
        .status(status), .slot(slot), .victim_handle(victim_handle),
        .needs_writeback(needs_writeback), .flush_empty(flush_empty), .last(last),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // cycle counter and timeout
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("tb_buffer_pool_slot_manager NOT OK");
            $finish;
        end
    end

    function automatic pool_result_t mk(logic [2:0] st, int sl, logic [31:0] vh,
                                        logic wb, logic fe, logic la);
        pool_result_t r;
        r.status = st;
        r.slot = sl[3:0];
        r.victim_handle = vh;
        r.needs_writeback = wb;
        r.flush_empty = fe;
        r.last = la;
        return r;
    endfunction

    // append one expected result
    function automatic void queue_result(pool_result_t r);
        pending_results = {pending_results, r};
    endfunction

    function automatic int find_slot(logic [31:0] h);
        for (int i = 0; i < used; i++)
            if (p_handle[i] == h) return i;
        return -1;
    endfunction

    function automatic void take_slot(int p);
        p_borrow[p] = 1'b1;
        if (p_use[p] != CNT_SAT) p_use[p] = p_use[p] + 16'd1;
        for (int i = 0; i < used; i++)
            if (i == p) p_gap[i] = '0;
            else if (p_gap[i] != CNT_SAT) p_gap[i] = p_gap[i] + 16'd1;
    endfunction

    function automatic void load_slot(int p, logic [31:0] h);
        p_handle[p] = h;
        p_use[p] = '0;
        p_gap[p] = '0;
        p_pin[p] = 1'b0;
        p_borrow[p] = 1'b0;
        p_dirty[p] = 1'b0;
    endfunction

    // least score among evictable slots, ties to the lowest
    function automatic int choose_victim();
        int best;
        longint best_score;
        longint s;
        best = -1;
        best_score = 0;
        for (int i = 0; i < used; i++)
        begin
            if (p_pin[i] || p_borrow[i]) continue;
            s = longint'(p_use[i]) * longint'(w_use) - longint'(p_gap[i]) * longint'(w_gap);
            if (best < 0 || s < best_score)
            begin
                best = i;
                best_score = s;
            end
        end
        return best;
    endfunction

    // update the shadow pool and queue the results that one item causes
    function automatic void predict_pool(logic [1:0] act, logic [31:0] h, logic md);
        int p;
        logic [31:0] vh;
        logic wb;
        p = find_slot(h);
        case (act)
            bpsm_pkg::ACT_GET:
            begin
                if (p >= 0)
                begin
                    take_slot(p);
                    queue_result(mk(bpsm_pkg::ST_HIT, p, '0, 1'b0, 1'b0, 1'b1));
                end
                else if (used < NSLOT)
                begin
                    p = used;
                    used++;
                    load_slot(p, h);
                    take_slot(p);
                    queue_result(mk(bpsm_pkg::ST_FILLED, p, '0, 1'b0, 1'b0, 1'b1));
                end
                else
                begin
                    p = choose_victim();
                    if (p < 0)
                        queue_result(mk(bpsm_pkg::ST_NOVICTIM, 0, '0, 1'b0, 1'b0, 1'b1));
                    else
                    begin
                        vh = p_handle[p];
                        wb = p_dirty[p];
                        load_slot(p, h);
                        take_slot(p);
                        queue_result(mk(bpsm_pkg::ST_REPLACED, p, vh, wb, 1'b0, 1'b1));
                    end
                end
            end
            bpsm_pkg::ACT_RETURN, bpsm_pkg::ACT_PIN:
            begin
                if (p < 0)
                    queue_result(mk(bpsm_pkg::ST_ABSENT, 0, '0, 1'b0, 1'b0, 1'b1));
                else
                begin
                    if (act == bpsm_pkg::ACT_RETURN)
                    begin
                        p_borrow[p] = 1'b0;
                        p_pin[p] = 1'b0;
                        if (md) p_dirty[p] = 1'b1;
                    end
                    else
                        p_pin[p] = 1'b1;
                    queue_result(mk(bpsm_pkg::ST_HIT, p, '0, 1'b0, 1'b0, 1'b1));
                end
            end
            default:
            begin
                if (used == 0)
                    queue_result(mk(bpsm_pkg::ST_FLUSH, 0, '0, 1'b0, 1'b1, 1'b1));
                else
                begin
                    for (int i = 0; i < used; i++)
                        queue_result(mk(bpsm_pkg::ST_FLUSH, i, p_handle[i],
                            p_dirty[i] | p_borrow[i], 1'b0, (i + 1 == used)));
                    used = 0;
                end
            end
        endcase
    endfunction

    // receiver: random stalls plus long hold-off, and the scoreboard
    always @(posedge clk or negedge rst_n)
    begin
        pool_result_t got;
        pool_result_t want;
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                got = {status, slot, victim_handle, needs_writeback, flush_empty, last};
                results_seen++;
                if (pending_results.size() == 0)
                begin
                    errors++;
                    if (mismatches++ < 10)
                        $display("unexpected result %h", got);
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (got !== want)
                    begin
                        errors++;
                        if (mismatches++ < 10)
                            $display({"mismatch: status %0d/%0d slot %0d/%0d vh %h/%h",
                                      " wb %b/%b fe %b/%b last %b/%b (exp/act)"},
                                want.status, got.status, want.slot, got.slot,
                                want.victim_handle, got.victim_handle,
                                want.needs_writeback, got.needs_writeback,
                                want.flush_empty, got.flush_empty, want.last, got.last);
                    end
                end
            end
            out_ready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // long receiver stall counted in its own process
    task automatic stall_receiver(int n);
        hold_off = 1'b1;
        repeat (n) @(posedge clk);
        hold_off = 1'b0;
    endtask

    // offer one item and wait for its transfer; valid stays up for the next one
    task automatic send_item(logic [1:0] act, logic [31:0] h, logic md);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        action <= act;
        handle <= h;
        mark_dirty <= md;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        predict_pool(act, h, md);
        items_sent++;
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic idx, logic [7:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        if (idx == bpsm_pkg::REG_USE_WEIGHT) w_use = val;
        else w_gap = val;
        @(posedge clk);
    endtask

    // handle from a small set so hits and evictions are common
    function automatic logic [31:0] pick_handle();
        if ($urandom_range(9) == 0) return $urandom;
        return 32'h100 + $urandom_range(23);
    endfunction

    task automatic test_directed();
        send_item(bpsm_pkg::ACT_FLUSH, '0, 1'b0);                // empty pool flush
        send_item(bpsm_pkg::ACT_RETURN, 32'hFFFF_FFFF, 1'b1);    // absent return
        send_item(bpsm_pkg::ACT_PIN, 32'h0, 1'b0);               // absent pin
        send_item(bpsm_pkg::ACT_GET, 32'h0, 1'b0);
        send_item(bpsm_pkg::ACT_GET, 32'hFFFF_FFFF, 1'b1);
        send_item(bpsm_pkg::ACT_GET, 32'h0, 1'b0);               // hit
        send_item(bpsm_pkg::ACT_RETURN, 32'h0, 1'b1);            // dirty return
        send_item(bpsm_pkg::ACT_PIN, 32'hFFFF_FFFF, 1'b0);
        send_item(bpsm_pkg::ACT_FLUSH, '0, 1'b1);                // busy flush
        // fill the pool, all borrowed: no victim
        for (int i = 0; i < NSLOT; i++) send_item(bpsm_pkg::ACT_GET, 32'hA000 + i, 1'b0);
        send_item(bpsm_pkg::ACT_GET, 32'h5555_AAAA, 1'b0);
        send_item(bpsm_pkg::ACT_RETURN, 32'hA003, 1'b1);
        send_item(bpsm_pkg::ACT_GET, 32'hAAAA_5555, 1'b0);       // replaces a dirty victim
        wait_drained();
    endtask

    task automatic test_random(int n);
        int r;
        for (int k = 0; k < n; k++)
        begin
            r = $urandom_range(99);
            if (r < 50)
                send_item(bpsm_pkg::ACT_GET, pick_handle(), 1'($urandom_range(1)));
            else if (r < 80)
                send_item(bpsm_pkg::ACT_RETURN, pick_handle(), 1'($urandom_range(1)));
            else if (r < 95)
                send_item(bpsm_pkg::ACT_PIN, pick_handle(), 1'($urandom_range(1)));
            else
                send_item(bpsm_pkg::ACT_FLUSH, $urandom, 1'($urandom_range(1)));
        end
    endtask

    task automatic test_backpressure();
        fork
            stall_receiver(300);
            for (int k = 0; k < 6; k++) send_item(bpsm_pkg::ACT_GET, pick_handle(), 1'b0);
        join
        send_item(bpsm_pkg::ACT_FLUSH, '0, 1'b0);
        wait_drained();
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        action = bpsm_pkg::ACT_GET;
        handle = '0;
        mark_dirty = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = bpsm_pkg::REG_USE_WEIGHT;
        cfg_data = '0;
        hold_off = 1'b0;
        items_sent = 0;
        used = 0;
        w_use = 8'd1;
        w_gap = 8'd1;
        send_idle_pct = 37;
        recv_idle_pct = 86;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        write_reg(bpsm_pkg::REG_USE_WEIGHT, 8'd255);
        write_reg(bpsm_pkg::REG_GAP_WEIGHT, 8'd0);
        test_random(30);
        wait_drained();

        send_idle_pct = 86;
        recv_idle_pct = 37;
        write_reg(bpsm_pkg::REG_USE_WEIGHT, 8'd0);
        write_reg(bpsm_pkg::REG_GAP_WEIGHT, 8'd255);
        test_random(30);
        wait_drained();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_reg(bpsm_pkg::REG_USE_WEIGHT, 8'($urandom_range(255)));
        write_reg(bpsm_pkg::REG_GAP_WEIGHT, 8'($urandom_range(255)));
        test_random(15);
        test_backpressure();

        $display("covered %0d items and %0d results over several weight settings,", items_sent,
            results_seen);
        $display("including no-victim, dirty eviction, empty and full flushes and stalls");
        if (errors == 0)
            $display("tb_buffer_pool_slot_manager OK");
        else
            $display("tb_buffer_pool_slot_manager NOT OK");
        $finish;
    end
endmodule

// File: files.f
+incdir+sv
sv/bpsm_pkg.sv
sv/bpsm_cell.sv
sv/buffer_pool_slot_manager.sv
sim/tb_buffer_pool_slot_manager.sv
